// ===== src/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

  // Storage geometry
  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Operation codes
  localparam logic [2:0] OP_INS_FRONT  = 3'd0;
  localparam logic [2:0] OP_INS_BACK   = 3'd1;
  localparam logic [2:0] OP_REM_FRONT  = 3'd2;
  localparam logic [2:0] OP_REM_BACK   = 3'd3;
  localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [2:0] OP_PEEK_BACK  = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] data_in;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic [1:0]  status;
    logic [6:0]  entry_count;
    logic        is_empty;
  } out_beat_t;

endpackage

// ===== src/double_ended_queue.sv =====
`timescale 1ns / 1ps

// Bounded double-ended queue of deq_pkg::DEPTH words in a single-port synchronous
// memory. Each input beat is one operation (insert, remove or peek at either end) and
// yields exactly one result beat. Pointers and the entry count update in the cycle the
// beat is accepted; a remove or peek reads the memory in that same cycle into a read
// register, and the word moves on to the output register when the read stage drains.
// One operation is taken every cycle while results are being drained, so throughput is
// one beat per cycle unless the output stalls; the single memory port (one read or one
// write per beat) allows no more than that. Empty removes and peeks return zero with an
// empty status; inserts into a full queue are dropped with a full status.
module double_ended_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  deq_pkg::in_beat_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output deq_pkg::out_beat_t   out_data
);

  localparam logic [deq_pkg::ADDR_W-1:0] LAST_SLOT = deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1);
  localparam logic [deq_pkg::CNT_W-1:0]  FULL_CNT  = deq_pkg::CNT_W'(deq_pkg::DEPTH);

  logic [deq_pkg::DATA_W-1:0] mem [deq_pkg::DEPTH];
  logic [deq_pkg::DATA_W-1:0] rd_data_r;

  logic [deq_pkg::ADDR_W-1:0] front_r, front_nxt;
  logic [deq_pkg::ADDR_W-1:0] back_r, back_nxt;
  logic [deq_pkg::CNT_W-1:0]  count_r, count_nxt;

  // Read stage: result awaiting the memory word
  logic                       pend_r;
  logic                       pend_rd_r, rd_nxt;
  logic [1:0]                 pend_st_r, st_nxt;
  logic [deq_pkg::CNT_W-1:0]  pend_cnt_r;

  logic                       out_valid_r;
  deq_pkg::out_beat_t         out_r;

  logic                       accept, pend_move;
  logic                       wr_en;
  logic [deq_pkg::ADDR_W-1:0] addr;
  logic [deq_pkg::ADDR_W-1:0] front_prev, front_next, back_prev, back_next;
  logic                       is_full, is_none;

  // Neighbouring slots with wrap
  assign front_prev = (front_r == '0) ? LAST_SLOT : front_r - 1'b1;
  assign front_next = (front_r == LAST_SLOT) ? '0 : front_r + 1'b1;
  assign back_prev  = (back_r == '0) ? LAST_SLOT : back_r - 1'b1;
  assign back_next  = (back_r == LAST_SLOT) ? '0 : back_r + 1'b1;

  assign is_full = (count_r == FULL_CNT);
  assign is_none = (count_r == '0);

  // Handshake: read stage drains whenever the output register is free or being taken;
  // hold off input beats while in reset
  assign pend_move = pend_r && (!out_valid_r || !out_stall);
  assign in_stall  = !rst_n || (pend_r && out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;

  // Decode the operation against the current pointers
  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    count_nxt = count_r;
    addr      = front_r;
    wr_en     = 1'b0;
    rd_nxt    = 1'b0;
    st_nxt    = deq_pkg::ST_OK;
    case (in_data.op)
      deq_pkg::OP_INS_FRONT: begin
        if (is_full) begin
          st_nxt = deq_pkg::ST_FULL;
        end else begin
          addr      = front_prev;
          wr_en     = 1'b1;
          front_nxt = front_prev;
          count_nxt = count_r + 1'b1;
        end
      end
      deq_pkg::OP_INS_BACK: begin
        if (is_full) begin
          st_nxt = deq_pkg::ST_FULL;
        end else begin
          addr      = back_r;
          wr_en     = 1'b1;
          back_nxt  = back_next;
          count_nxt = count_r + 1'b1;
        end
      end
      deq_pkg::OP_REM_FRONT: begin
        if (is_none) begin
          st_nxt = deq_pkg::ST_EMPTY;
        end else begin
          addr      = front_r;
          rd_nxt    = 1'b1;
          front_nxt = front_next;
          count_nxt = count_r - 1'b1;
        end
      end
      deq_pkg::OP_REM_BACK: begin
        if (is_none) begin
          st_nxt = deq_pkg::ST_EMPTY;
        end else begin
          addr      = back_prev;
          rd_nxt    = 1'b1;
          back_nxt  = back_prev;
          count_nxt = count_r - 1'b1;
        end
      end
      deq_pkg::OP_PEEK_FRONT: begin
        if (is_none) begin
          st_nxt = deq_pkg::ST_EMPTY;
        end else begin
          addr   = front_r;
          rd_nxt = 1'b1;
        end
      end
      deq_pkg::OP_PEEK_BACK: begin
        if (is_none) begin
          st_nxt = deq_pkg::ST_EMPTY;
        end else begin
          addr   = back_prev;
          rd_nxt = 1'b1;
        end
      end
      default: begin
        st_nxt = deq_pkg::ST_OK;
      end
    endcase
  end

  // Entry store: one write or one read per accepted beat
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[addr] <= in_data.data_in[deq_pkg::DATA_W-1:0];
    end
    if (accept && rd_nxt) begin
      rd_data_r <= mem[addr];
    end
  end

  // Pointers, count and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      back_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        front_r <= front_nxt;
        back_r  <= back_nxt;
        count_r <= count_nxt;
      end
      if (accept) begin
        pend_r <= 1'b1;
      end else if (pend_move) begin
        pend_r <= 1'b0;
      end
      if (pend_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the beat's status while its word is read
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_rd_r  <= rd_nxt;
      pend_st_r  <= st_nxt;
      pend_cnt_r <= count_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_r.data_out    <= pend_rd_r ? 32'(rd_data_r) : '0;
      out_r.status      <= pend_st_r;
      out_r.entry_count <= 7'(pend_cnt_r);
      out_r.is_empty    <= (pend_cnt_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
